FILE: sv/font_cmap_glyph_lookup_macros.svh
// Assertion macros for the glyph lookup block
`ifndef FONT_CMAP_GLYPH_LOOKUP_MACROS_SVH
`define FONT_CMAP_GLYPH_LOOKUP_MACROS_SVH
`define FCG_ASSERT_IMPL(lbl, clk_s, rst_s, pre, post) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (pre) |-> (post)) \
    else $error("assertion failed");
`define FCG_ASSERT_NEXT(lbl, clk_s, rst_s, pre, post) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

FILE: sv/fcg_pkg.sv
// Shared types and constants for the glyph lookup block
package fcg_pkg;
  localparam int TableWordsDefault = 32768;
  localparam int QueueDepth = 2;
  localparam logic [2:0] FmtByte = 3'd0;
  localparam logic [2:0] FmtHighByte = 3'd2;
  localparam logic [2:0] FmtSegment = 3'd4;
  localparam logic ActWrite = 1'b0;
  localparam logic ActLookup = 1'b1;

  typedef struct packed {
    logic        is_lookup;
    logic [14:0] addr;
    logic [15:0] data;
    logic [15:0] code;
    logic        miss;
  } fcg_cmd_t;
endpackage

FILE: sv/fcg_front.sv
// Front end: accept beats, classify them and queue commands
module fcg_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic             action,
  input  logic [14:0]      word_addr,
  input  logic [15:0]      word_data,
  input  logic [20:0]      code_point,
  output fcg_pkg::fcg_cmd_t cmd,
  output logic             cmd_valid,
  input  logic             cmd_take
);
  import fcg_pkg::*;
  `include "font_cmap_glyph_lookup_macros.svh"

  fcg_cmd_t q [QueueDepth];
  logic     wp, rp;
  logic [1:0] cnt;
  logic     do_push, do_pop;

  assign full      = (cnt == 2'(QueueDepth));
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rp];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop) rp <= ~rp;
      cnt <= cnt + 2'(do_push) - 2'(do_pop);
    end
    if (do_push) begin
      q[wp].is_lookup <= (action == ActLookup);
      q[wp].addr      <= word_addr;
      q[wp].data      <= word_data;
      q[wp].code      <= code_point[15:0];
      q[wp].miss      <= (code_point[20:16] != 5'd0);
    end
  end

  `FCG_ASSERT_IMPL(a_cnt_range, clk, rst, 1'b1, cnt <= 2'(QueueDepth))
  `FCG_ASSERT_NEXT(a_push_grows, clk, rst, do_push && !do_pop, cnt == $past(cnt) + 2'd1)
  `FCG_ASSERT_NEXT(a_pop_shrinks, clk, rst, do_pop && !do_push, cnt == $past(cnt) - 2'd1)
endmodule

FILE: sv/fcg_back.sv
// Back end: subtable store and lookup sequencer
module fcg_back #(
  parameter int TABLE_WORDS = fcg_pkg::TableWordsDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [2:0]        fmt,
  input  fcg_pkg::fcg_cmd_t cmd,
  input  logic              cmd_valid,
  output logic              cmd_take,
  output logic              empty,
  input  logic              pop,
  output logic [15:0]       glyph_id
);
  import fcg_pkg::*;
  `include "font_cmap_glyph_lookup_macros.svh"

  localparam int AW = $clog2(TABLE_WORDS);

  typedef enum logic [3:0] {
    S_IDLE, S_F0, S_KEY, S_SH0, S_SH1, S_SH2, S_SH3, S_G2, S_SEGS,
    S_WALK, S_START, S_DELTA, S_RO, S_ROFS, S_G4, S_DONE
  } state_t;

  logic [15:0] mem [TABLE_WORDS];
  logic [15:0] rdata;
  logic [AW-1:0] raddr;
  logic        rd_en;
  state_t      state;
  logic [15:0] code, first, count, delta, start, segs, idx;
  logic [AW-1:0] base;
  logic        out_full;
  logic [15:0] out_q;

  assign empty    = !out_full;
  assign glyph_id = out_q;
  assign cmd_take = (state == S_IDLE) && cmd_valid &&
                    (!cmd.is_lookup || !out_full || pop);

  always_ff @(posedge clk) begin
    if (cmd_take && !cmd.is_lookup) mem[cmd.addr[AW-1:0]] <= cmd.data;
    rdata <= mem[raddr];
  end

  logic [15:0] lo_rel;
  logic [15:0] seg_lim;
  assign lo_rel  = {8'd0, code[7:0]} - first;
  assign seg_lim = segs;

  always_comb begin
    raddr = '0;
    rd_en = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (fmt == FmtHighByte) raddr = AW'(16'd3 + {8'd0, cmd.code[15:8]});
        else if (fmt == FmtSegment) raddr = AW'(3);
        else raddr = AW'(16'd3 + {1'b0, cmd.code[15:1]});
      end
      S_KEY:   raddr = AW'(32'd259 + {16'd0, rdata[15:3], 2'b00});
      S_SH0:   raddr = base + AW'(1);
      S_SH1:   raddr = base + AW'(2);
      S_SH2:   raddr = base + AW'(3);
      S_SH3:   raddr = base + AW'(3) + AW'(rdata[15:1]) + AW'(lo_rel);
      S_SEGS:  raddr = AW'(7);
      S_WALK:  raddr = AW'(32'd7 + {16'd0, idx} + 32'd1);
      S_START: raddr = AW'(32'd8 + {16'd0, segs} + {16'd0, idx});
      S_DELTA: raddr = AW'(32'd8 + {15'd0, segs, 1'b0} + {16'd0, idx});
      S_RO:    raddr = base;
      S_ROFS:  raddr = base + AW'(rdata[15:1]) + AW'(code - start);
      default: raddr = '0;
    endcase
    rd_en = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_full <= 1'b0;
    end else begin
      if (pop && out_full) out_full <= 1'b0;
      unique case (state)
        S_IDLE: if (cmd_take && cmd.is_lookup) begin
          code <= cmd.code;
          if (fmt == FmtByte && !cmd.miss && cmd.code[15:8] == 8'd0) state <= S_F0;
          else if (fmt == FmtHighByte && !cmd.miss) begin
            state <= S_KEY;
          end else if (fmt == FmtSegment && !cmd.miss) state <= S_SEGS;
          else begin
            out_q <= 16'd0;
            state <= S_DONE;
          end
        end
        S_F0: begin
          out_q <= code[0] ? {8'd0, rdata[7:0]} : {8'd0, rdata[15:8]};
          state <= S_DONE;
        end
        S_KEY: begin
          base  <= raddr;
          state <= S_SH0;
        end
        S_SH0: begin first <= rdata; state <= S_SH1; end
        S_SH1: begin count <= rdata; state <= S_SH2; end
        S_SH2: begin delta <= rdata; state <= S_SH3; end
        S_SH3: begin
          if ({8'd0, code[7:0]} < first || lo_rel >= count) begin
            out_q <= 16'd0;
            state <= S_DONE;
          end else state <= S_G2;
        end
        S_G2, S_G4: begin
          out_q <= (rdata == 16'd0) ? 16'd0 : rdata + delta;
          state <= S_DONE;
        end
        S_SEGS: begin
          segs <= {1'b0, rdata[15:1]};
          idx <= 16'd0;
          if (rdata[15:1] == 15'd0) begin
            out_q <= 16'd0;
            state <= S_DONE;
          end else state <= S_WALK;
        end
        S_WALK: begin
          if (rdata >= code) state <= S_START;
          else if (idx + 16'd1 >= seg_lim) begin
            out_q <= 16'd0;
            state <= S_DONE;
          end else idx <= idx + 16'd1;
        end
        S_START: state <= S_DELTA;
        S_DELTA: begin
          start <= rdata;
          if (code < rdata) begin
            out_q <= 16'd0;
            state <= S_DONE;
          end else state <= S_RO;
          base <= AW'(32'd8 + 32'd3 * {16'd0, segs} + {16'd0, idx});
        end
        S_RO: begin
          delta <= rdata;
          state <= S_ROFS;
        end
        S_ROFS: begin
          if (rdata == 16'd0) begin
            out_q <= code + delta;
            state <= S_DONE;
          end else state <= S_G4;
        end
        S_DONE: begin
          out_full <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `FCG_ASSERT_NEXT(a_done_fills, clk, rst, state == S_DONE, out_full)
  `FCG_ASSERT_IMPL(a_take_idle, clk, rst, cmd_take, state == S_IDLE)
  `FCG_ASSERT_IMPL(a_rd_on, clk, rst, 1'b1, rd_en)
endmodule

FILE: sv/font_cmap_glyph_lookup.sv
// Top level of the character-map glyph lookup block
// Usage:
//   Input queue (push/full) takes write beats (action 0) that load one
//   16-bit subtable word, and lookup beats (action 1) that map a code point.
//   Result queue (empty/pop) gives one glyph_id per lookup, none per write.
//   table_format is written through cfg_we/cfg_data while the block is idle;
//   the user must keep to this, as the block itself does not enforce it.
// Sequencing:
//   A write is taken while the sequencer is idle and leaves it idle. Lookups
//   read the table one word at a time through its single read port; format 4
//   also walks the segment end codes. A two-entry command queue lets the front accept while the back works.
// Reset clears queues, the sequencer and table_format; table contents are
// undefined until written.
// When the receiver stalls, the finished result is held, the back end stops
// at its next lookup and the command queue fills, then full rises.
module font_cmap_glyph_lookup #(
  parameter int TABLE_WORDS = fcg_pkg::TableWordsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_data,
  input  logic        push,
  output logic        full,
  input  logic        action,
  input  logic [14:0] word_addr,
  input  logic [15:0] word_data,
  input  logic [20:0] code_point,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] glyph_id
);
  import fcg_pkg::*;

  logic [2:0] table_format;
  fcg_cmd_t   cmd;
  logic       cmd_valid, cmd_take;

  always_ff @(posedge clk) begin
    if (rst) table_format <= FmtByte;
    else if (cfg_we) table_format <= cfg_data;
  end

  fcg_front u_front (
    .clk, .rst, .push, .full, .action, .word_addr, .word_data, .code_point,
    .cmd, .cmd_valid, .cmd_take
  );

  fcg_back #(.TABLE_WORDS(TABLE_WORDS)) u_back (
    .clk, .rst, .fmt(table_format), .cmd, .cmd_valid, .cmd_take,
    .empty, .pop, .glyph_id
  );
endmodule

FILE: tb/sv/tb.sv
// Testbench for the character-map glyph lookup block, with its own glyph predictor
module tb;
  import fcg_pkg::*;

  localparam int StoreWords = 32768;
  localparam int RegionWords = 640;
  localparam int IdleLimit = 20000;
  localparam logic [2:0] FmtUnused1 = 3'd1;
  localparam logic [2:0] FmtUnused3 = 3'd3;
  localparam logic [2:0] FmtUnused5 = 3'd5;
  localparam logic [2:0] FmtUnused6 = 3'd6;
  localparam logic [2:0] FmtUnused7 = 3'd7;

  class glyph_scoreboard;
    logic [15:0] words[StoreWords];
    bit written[StoreWords];
    logic [2:0] fmt;
    logic [15:0] glyphs_due[$];
    int errors;

    function int unsigned word_at(int unsigned a, inout bit clean);
      a = a % StoreWords;
      if (!written[a]) clean = 0;
      return written[a] ? words[a] : 0;
    endfunction

    function logic [15:0] glyph_for(logic [20:0] code, output bit clean);
      int unsigned hi, lo, key, sh, first, count, delta, ro, g, segs, i, start, roaddr, w;
      int unsigned sum;
      clean = 1;
      if (fmt == FmtByte) begin
        if (code > 21'hFF) return 0;
        w = word_at(3 + (code >> 1), clean);
        return code[0] ? w[7:0] : w[15:8];
      end else if (fmt == FmtHighByte) begin
        if (code > 21'hFFFF) return 0;
        hi = code >> 8;
        lo = code & 8'hFF;
        key = word_at(3 + hi, clean);
        sh = 259 + (key >> 3) * 4;
        first = word_at(sh, clean);
        count = word_at(sh + 1, clean);
        delta = word_at(sh + 2, clean);
        ro = word_at(sh + 3, clean);
        if (lo < first || lo - first >= count) return 0;
        g = word_at(sh + 3 + (ro >> 1) + (lo - first), clean);
        if (g == 0) return 0;
        sum = g + delta;
        return sum[15:0];
      end else if (fmt == FmtSegment) begin
        if (code > 21'hFFFF) return 0;
        segs = word_at(3, clean) >> 1;
        for (i = 0; i < segs; i++)
          if (word_at(7 + i, clean) >= code) break;
        if (i >= segs) return 0;
        start = word_at(8 + segs + i, clean);
        if (code < start) return 0;
        delta = word_at(8 + 2 * segs + i, clean);
        roaddr = 8 + 3 * segs + i;
        ro = word_at(roaddr, clean);
        if (ro == 0) begin
          sum = code + delta;
          return sum[15:0];
        end
        g = word_at(roaddr + (ro >> 1) + (code - start), clean);
        if (g == 0) return 0;
        sum = g + delta;
        return sum[15:0];
      end
      return 0;
    endfunction

    function void note_beat(logic act, logic [14:0] addr, logic [15:0] data,
                            logic [20:0] code);
      bit clean;
      if (act == ActWrite) begin
        words[addr] = data;
        written[addr] = 1;
      end else begin
        glyphs_due.push_back(glyph_for(code, clean));
      end
    endfunction

    function void check_glyph(logic [15:0] g);
      logic [15:0] e;
      if (glyphs_due.size() == 0) begin
        $display("%0t unexpected glyph beat: expected none, actual %h", $time, g);
        errors++;
        return;
      end
      e = glyphs_due.pop_front();
      if (g !== e) begin
        $display("%0t glyph_id mismatch: expected %h, actual %h", $time, e, g);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst, cfg_we, push, full, action, empty, pop;
  logic [2:0] cfg_data;
  logic [14:0] word_addr;
  logic [15:0] word_data, glyph_id;
  logic [20:0] code_point;

  glyph_scoreboard sb;
  logic [15:0] img[RegionWords];
  int unsigned hot[$];
  int burst_left;
  int gap_max;
  int stall_pct;
  int idle_cycles;

  font_cmap_glyph_lookup u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .push(push), .full(full), .action(action), .word_addr(word_addr),
    .word_data(word_data), .code_point(code_point),
    .empty(empty), .pop(pop), .glyph_id(glyph_id)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    pop <= rst ? 1'b0 : ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) sb.check_glyph(glyph_id);
    if ((push && !full) || (pop && !empty)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > IdleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send(logic act, logic [14:0] addr, logic [15:0] data, logic [20:0] code);
    push <= 1'b1;
    action <= act;
    word_addr <= addr;
    word_data <= data;
    code_point <= code;
    do @(posedge clk); while (full);
    sb.note_beat(act, addr, data, code);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      if (gap_max > 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(negedge clk);
      end
    end
  endtask

  task automatic drain_and_set(logic [2:0] f);
    push <= 1'b0;
    while (sb.glyphs_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= f;
    sb.fmt = f;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_span(int lo, int hi);
    for (int a = lo; a <= hi; a++) send(ActWrite, 15'(a), img[a], 21'($urandom()));
  endtask

  task automatic build_table(logic [2:0] f);
    int n, i, s, base, prev, e, st, sh;
    hot.delete();
    foreach (img[k]) img[k] = ($urandom_range(0, 7) == 0) ? 16'h0 : 16'($urandom());
    img[0] = {13'h0, f};
    img[1] = 16'(RegionWords * 2);
    if (f == FmtByte) begin
      repeat (30) hot.push_back($urandom_range(0, 255));
      write_span(0, 130);
    end else if (f == FmtHighByte) begin
      for (i = 0; i < 16; i++)
        img[3 + i] = ($urandom_range(0, 20) == 0) ? 16'($urandom())
                     : 16'(($urandom_range(0, 7) << 3) | $urandom_range(0, 7));
      for (s = 0; s < 8; s++) begin
        sh = 259 + 4 * s;
        base = 300 + s * 12;
        img[sh] = ($urandom_range(0, 3) == 0) ? 16'h0 : 16'($urandom_range(0, 255));
        img[sh + 1] = 16'($urandom_range(0, 10));
        img[sh + 2] = 16'($urandom());
        img[sh + 3] = 16'(2 * (base - (sh + 3)) + $urandom_range(0, 1));
      end
      repeat (40) begin
        i = $urandom_range(0, 15);
        s = img[3 + i] >> 3;
        st = (s < 8) ? img[259 + 4 * s] : 0;
        e = st + $urandom_range(0, 11) - 1;
        hot.push_back((i << 8) | (e & 8'hFF));
      end
      write_span(0, 18);
      write_span(259, 290);
      write_span(300, 395);
    end else begin
      n = $urandom_range(1, 8);
      img[3] = 16'(2 * n + ($urandom_range(0, 3) == 0));
      prev = -1;
      for (i = 0; i < n; i++) begin
        e = prev + 1 + $urandom_range(0, (65534 - prev) / (n - i));
        if (i == n - 1 && $urandom_range(0, 1)) e = 16'hFFFF;
        if (e > 16'hFFFF) e = 16'hFFFF;
        prev = e;
        st = (e >= 10) ? e - $urandom_range(0, 10) : 0;
        if ($urandom_range(0, 7) == 0) st = (e < 16'hFFFF) ? e + 1 : e;
        base = 100 + i * 12;
        img[7 + i] = 16'(e);
        img[8 + n + i] = 16'(st);
        img[8 + 2 * n + i] = 16'($urandom());
        img[8 + 3 * n + i] = ($urandom_range(0, 2) == 0) ? 16'h0
                             : 16'(2 * (base - (8 + 3 * n + i)) + $urandom_range(0, 1));
        hot.push_back(e);
        hot.push_back((e + 1) & 16'hFFFF);
        hot.push_back(st);
        hot.push_back((st > 0) ? st - 1 : 0);
        repeat (4) hot.push_back((st <= e) ? $urandom_range(st, e) : e);
      end
      img[7 + n] = 0;
      write_span(0, 39);
      write_span(100, 195);
    end
  endtask

  task automatic lookups(int count);
    int unsigned extremes[8] = '{0, 1, 8'hFF, 12'h100, 16'hFFFE, 16'hFFFF,
                                 21'h10000, 21'h1FFFFF};
    logic [20:0] c;
    bit clean;
    int tries;
    repeat (count) begin
      if ($urandom_range(0, 9) == 0) begin
        send(ActWrite, ($urandom_range(0, 3) == 0) ? 15'h7FFF
                       : 15'($urandom_range(RegionWords, StoreWords - 1)),
             ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom()),
             21'($urandom()));
      end
      tries = 0;
      do begin
        case ($urandom_range(0, 5))
          0: c = 21'(extremes[$urandom_range(0, 7)]);
          1: c = 21'($urandom_range(0, 21'h1FFFFF));
          2: c = 21'($urandom_range(0, 16'hFFFF));
          3: c = 21'($urandom_range(0, 8'hFF));
          default: c = (hot.size() != 0) ? 21'(hot[$urandom_range(0, hot.size() - 1)])
                                          : 21'($urandom_range(0, 8'hFF));
        endcase
        void'(sb.glyph_for(c, clean));
        tries++;
      end while (!clean && tries < 20);
      if (!clean) c = 21'h10000 | 21'($urandom_range(0, 21'hFFFF));
      send(ActLookup, 15'($urandom()), 16'($urandom()), c);
    end
  endtask

  initial begin
    logic [2:0] plan[8] = '{FmtHighByte, FmtSegment, FmtUnused1, FmtUnused3,
                            FmtUnused5, FmtUnused6, FmtUnused7, FmtByte};
    sb = new();
    sb.fmt = FmtByte;
    clk = 0; rst = 1; cfg_we = 0; cfg_data = 0; push = 0; action = 0;
    word_addr = 0; word_data = 0; code_point = 0; pop = 0;
    burst_left = 0; gap_max = 0; stall_pct = 0; idle_cycles = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    build_table(FmtByte);
    lookups(40);
    foreach (plan[p]) begin
      gap_max = (p % 3 == 0) ? 0 : 6;
      stall_pct = (p % 4 == 0) ? 0 : (p % 4 == 1) ? 40 : (p % 4 == 2) ? 80 : 95;
      drain_and_set(plan[p]);
      if (plan[p] == FmtHighByte || plan[p] == FmtSegment) begin
        build_table(plan[p]);
        lookups(65);
      end else if (plan[p] == FmtByte) begin
        lookups(30);
      end else begin
        lookups(10);
      end
    end
    push <= 1'b0;
    while (sb.glyphs_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
